// File: hdl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Types and constants shared by the signed multiply-divide pipeline.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int unsigned OPW  = 32;          // operand and result width
    localparam int unsigned PRW  = 2 * OPW - 1; // product magnitude width
    localparam int unsigned NCEL = PRW;         // one quotient bit per cell

    typedef struct packed {
        logic signed [OPW-1:0] multiplicand;
        logic signed [OPW-1:0] multiplier;
        logic signed [OPW-1:0] divisor;
    } t_in;

    typedef struct packed {
        logic signed [OPW-1:0] quotient_out;
        logic                  overflow;
        logic                  divide_by_zero;
    } t_out;

    // State that one divider cell hands to the next.
    typedef struct packed {
        logic [PRW-1:0] work;   // dividend bits shift out on top, quotient in below
        logic [OPW-1:0] rem;    // partial remainder, below dvs unless the divisor is zero
        logic [OPW-1:0] dvs;    // divisor magnitude
        logic           neg;    // sign of the final result
        logic           dbz;    // divisor was zero
    } t_cell;

endpackage

// File: hdl/smd_front.sv
// ----------------------------------------------------------------------------
// smd_front
// Input register, operand magnitudes and the 32x32 product register.
// ----------------------------------------------------------------------------
module smd_front
    import smd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_word,
    output logic  o_valid,
    output t_cell o_cell
);

    logic           r_in_valid;
    t_in            r_in;
    logic           r_valid;
    t_cell          r_cell;

    logic           neg_a, neg_b, neg_c;
    logic [OPW-1:0] mag_a, mag_b, mag_c;
    logic [PRW-1:0] prod;
    t_cell          n_cell;

    always_comb begin
        neg_a = r_in.multiplicand[OPW-1];
        neg_b = r_in.multiplier[OPW-1];
        neg_c = r_in.divisor[OPW-1];
        // The most negative value maps to 2^31, which still fits unsigned.
        mag_a = neg_a ? (~r_in.multiplicand + OPW'(1)) : r_in.multiplicand;
        mag_b = neg_b ? (~r_in.multiplier + OPW'(1))   : r_in.multiplier;
        mag_c = neg_c ? (~r_in.divisor + OPW'(1))      : r_in.divisor;
        // Both magnitudes are at most 2^31, so the product fits in 63 bits.
        prod  = PRW'(mag_a) * PRW'(mag_b);
        n_cell.work = prod;
        n_cell.rem  = '0;
        n_cell.dvs  = mag_c;
        n_cell.neg  = neg_a ^ neg_b ^ neg_c;
        n_cell.dbz  = (mag_c == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else if (i_en) begin
            r_in_valid <= i_valid;
            r_valid    <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in   <= i_word;
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// File: hdl/smd_div_cell.sv
// ----------------------------------------------------------------------------
// smd_div_cell
// One restoring-division step: retire one dividend bit, produce one quotient bit.
// ----------------------------------------------------------------------------
module smd_div_cell
    import smd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cell i_cell,
    output logic  o_valid,
    output t_cell o_cell
);

    logic           r_valid;
    t_cell          r_cell;

    logic [OPW:0]   trial;
    logic [OPW-1:0] diff;
    logic           ge;
    t_cell          n_cell;

    always_comb begin
        trial  = {i_cell.rem, i_cell.work[PRW-1]};
        // When the trial covers a nonzero divisor the difference is below it.
        diff   = trial[OPW-1:0] - i_cell.dvs;
        ge     = (trial >= {1'b0, i_cell.dvs});
        n_cell = i_cell;
        n_cell.rem  = ge ? diff : trial[OPW-1:0];
        n_cell.work = {i_cell.work[PRW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// File: hdl/smd_back.sv
// ----------------------------------------------------------------------------
// smd_back
// Sign, overflow and zero-divisor handling, output register and skid stage.
// ----------------------------------------------------------------------------
module smd_back
    import smd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cell i_cell,
    input  logic  i_stall,
    output logic  o_valid,
    output t_out  o_word,
    output logic  o_full
);

    logic           r_out_valid;
    t_out           r_out;
    logic           r_skid_valid;
    t_out           r_skid;

    logic [PRW-1:0] q;
    logic           take;
    logic           push;
    t_out           n_res;

    always_comb begin
        q = i_cell.work;
        if (i_cell.dbz) begin
            n_res.quotient_out   = '0;
            n_res.overflow       = 1'b0;
            n_res.divide_by_zero = 1'b1;
        end else begin
            n_res.quotient_out   = i_cell.neg ? (~q[OPW-1:0] + OPW'(1)) : q[OPW-1:0];
            // Negative results may reach -2^31, positive ones only 2^31-1.
            n_res.overflow       = i_cell.neg
                ? ((|q[PRW-1:OPW]) || (q[OPW-1] && (|q[OPW-2:0])))
                : (|q[PRW-1:OPW-1]);
            n_res.divide_by_zero = 1'b0;
        end
    end

    assign take = r_out_valid && !i_stall;
    assign push = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !take) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;
    assign o_full  = r_skid_valid;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.divide_by_zero) |->
            (r_out.quotient_out == '0 && !r_out.overflow))
        else $error("zero divisor word carries a nonzero result");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (!r_skid_valid && r_out_valid))
        else $error("skid word not moved to output");

endmodule

// File: hdl/signed_mul_div_64bit_intermediate.sv
// ----------------------------------------------------------------------------
// signed_mul_div_64bit_intermediate
// Signed (a*b)/c with a 64-bit product, truncated toward zero.
// ----------------------------------------------------------------------------
// Pipeline: input register, product register, 63 division cells, then the
//   output register, from an accepted input word to its output word.
// Throughput: one word per cycle while o_stall is low; the chain of 63
//   restoring-division cells, one quotient bit each, plus the front, output
//   and skid registers holds up to 67 words in flight.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
module signed_mul_div_64bit_intermediate
    import smd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_word,
    output logic o_stall,
    output logic o_valid,
    output t_out o_word,
    input  logic i_stall
);

    // The whole chain advances together; it halts only while the skid stage
    // holds a word, so a finished result can wait without blocking intake.
    logic  en;
    logic  full;

    logic  c_valid [NCEL+1];
    t_cell c_cell  [NCEL+1];

    assign en      = !full;
    assign o_stall = full;

    // Front end: magnitudes and product feed cell 0.
    smd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_valid (c_valid[0]),
        .o_cell  (c_cell[0])
    );

    // Division chain: each cell retires the top dividend bit and shifts a
    // quotient bit in at the bottom of the work word.
    for (genvar g = 0; g < NCEL; g++) begin : g_cell
        smd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_cell  (c_cell[g]),
            .o_valid (c_valid[g+1]),
            .o_cell  (c_cell[g+1])
        );
    end

    // Back end: apply sign, flag overflow and zero divisor, hold for the sink.
    smd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[NCEL]),
        .i_cell  (c_cell[NCEL]),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_word  (o_word),
        .o_full  (full)
    );

endmodule
